[hw/rtl/epmc_pkg.sv]
// ----------------------------------------------------------------------------
// epmc_pkg
// Shared widths, constants, register indexes and helpers for the encoder PID
// motor controller.
// ----------------------------------------------------------------------------
package epmc_pkg;

  localparam int CNT_W   = 16;
  localparam int DATA_W  = 32;
  localparam int GAIN_W  = 16;
  localparam int TICK_W  = 17;
  localparam int PID_W   = 51;
  localparam int CTL_W   = 15;
  localparam int LIMIT_W = 14;
  localparam int LEVEL_W = 7;

  localparam logic signed [TICK_W-1:0] WRAP_THRESHOLD = 17'sd30000;
  localparam logic [TICK_W-1:0]        COUNT_SPAN     = 17'h10000;
  localparam logic [LEVEL_W-1:0]       LEVEL_IDLE     = 7'd100;

  // floor(x / 125) == (x * DIV125_RECIP) >> DIV125_SHIFT for any 48-bit x
  localparam int          DIV125_SHIFT = 55;
  localparam logic [48:0] DIV125_RECIP = 49'(((64'd1 << 55) + 64'd124) / 64'd125);

  // floor(x / 100) for any 14-bit x
  localparam int          DIV100_SHIFT = 21;
  localparam logic [14:0] DIV100_RECIP = 15'(((32'd1 << 21) + 32'd99) / 32'd100);

  typedef enum logic [2:0] {
    CFG_POS_P     = 3'd0,
    CFG_POS_I     = 3'd1,
    CFG_POS_D     = 3'd2,
    CFG_SPEED_P   = 3'd3,
    CFG_SPEED_I   = 3'd4,
    CFG_SPEED_D   = 3'd5,
    CFG_LOOP_MODE = 3'd6,
    CFG_LIMIT     = 3'd7
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_POS   = 2'd1,
    MODE_SPEED = 2'd2,
    MODE_BOTH  = 2'd3
  } loop_mode_t;

  // per-request data that rides along beside the PID lanes
  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic signed [DATA_W-1:0] perr;
    logic                     speed_zero;
    logic                     homing;
  } side_t;

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W:0] v);
    logic signed [DATA_W-1:0] r;
    if (v[DATA_W] != v[DATA_W-1]) begin
      r = v[DATA_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

[hw/rtl/encoder_pid_motor_controller_unit.sv]
// ----------------------------------------------------------------------------
// encoder_pid_motor_controller_unit
// One request per cycle; while out_ready is low, only until all stages fill.
// The divide-by-1000 pipeline in the PID lanes forms stages S4..S8.
// Stages advance independently, so requests keep entering while a result waits.
// Reset: registers to defaults, state cleared, motor active, compares at 100.
// ----------------------------------------------------------------------------
module encoder_pid_motor_controller_unit
  import epmc_pkg::*;
#(
  parameter int unsigned STALL_LIMIT_HOMING      = 500,
  parameter int unsigned STALL_LIMIT_NORMAL      = 100,
  parameter int unsigned STALL_CONTROL_THRESHOLD = 5000,
  parameter int unsigned SPEED_SCALE             = 365
)
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write_en,
  input  logic [2:0]                cfg_index,
  input  logic [GAIN_W-1:0]         cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [CNT_W-1:0]          encoder_count,
  input  logic signed [DATA_W-1:0]  target_position,
  input  logic signed [DATA_W-1:0]  target_speed,
  input  logic                      homing_active,
  input  logic                      clear_position,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DATA_W-1:0]  position,
  output logic signed [DATA_W-1:0]  position_error,
  output logic signed [CTL_W-1:0]   control_value,
  output logic [LEVEL_W-1:0]        ccw_compare,
  output logic [LEVEL_W-1:0]        cw_compare,
  output logic                      motor_active,
  output logic                      stall_fault
);

  localparam int NSTG = 10;
  localparam logic [11:0]              SCALE       = 12'(SPEED_SCALE);
  localparam logic signed [CTL_W-1:0]  STALL_THR   = CTL_W'(STALL_CONTROL_THRESHOLD);
  localparam logic [CNT_W:0]           LIM_HOMING  = 17'(STALL_LIMIT_HOMING);
  localparam logic [CNT_W:0]           LIM_NORMAL  = 17'(STALL_LIMIT_NORMAL);

  // ---------------- configuration ----------------
  logic [GAIN_W-1:0]  pos_gain_p_centi;
  logic [GAIN_W-1:0]  pos_gain_i_milli;
  logic [GAIN_W-1:0]  pos_gain_d;
  logic [GAIN_W-1:0]  speed_gain_p_centi;
  logic [GAIN_W-1:0]  speed_gain_i_milli;
  logic [GAIN_W-1:0]  speed_gain_d;
  logic [1:0]         loop_mode;
  logic [LIMIT_W-1:0] control_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_gain_p_centi   <= 16'd250;
      pos_gain_i_milli   <= 16'd0;
      pos_gain_d         <= 16'd250;
      speed_gain_p_centi <= 16'd200;
      speed_gain_i_milli <= 16'd0;
      speed_gain_d       <= 16'd200;
      loop_mode          <= MODE_POS;
      control_limit      <= 14'd6667;
    end else if (cfg_write_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POS_P:     pos_gain_p_centi   <= cfg_data;
        CFG_POS_I:     pos_gain_i_milli   <= cfg_data;
        CFG_POS_D:     pos_gain_d         <= cfg_data;
        CFG_SPEED_P:   speed_gain_p_centi <= cfg_data;
        CFG_SPEED_I:   speed_gain_i_milli <= cfg_data;
        CFG_SPEED_D:   speed_gain_d       <= cfg_data;
        CFG_LOOP_MODE: loop_mode          <= cfg_data[1:0];
        CFG_LIMIT:     control_limit      <= cfg_data[LIMIT_W-1:0];
      endcase
    end
  end

  // ---------------- stage flow control ----------------
  logic [NSTG-1:0] stg_valid;
  logic [NSTG-1:0] stg_adv;
  logic [NSTG-1:0] stg_feed;

  assign stg_feed = {stg_valid[NSTG-2:0], in_valid};

  always_comb begin
    stg_adv[NSTG-1] = !stg_valid[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_adv[k] = !stg_valid[k] || stg_adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (stg_adv[k]) stg_valid[k] <= stg_feed[k];
      end
    end
  end

  assign in_ready  = stg_adv[0];
  assign out_valid = stg_valid[NSTG-1];

  // ---------------- S1: encoder delta, position, error ----------------
  logic [CNT_W-1:0]          previous_count;
  logic signed [DATA_W-1:0]  position_acc;
  logic [CNT_W-1:0]          prev_base;
  logic signed [DATA_W-1:0]  pos_base;
  logic signed [TICK_W-1:0]  diff;
  logic signed [TICK_W-1:0]  ticks;
  logic signed [DATA_W-1:0]  pos_new;
  logic signed [DATA_W-1:0]  perr_new;

  always_comb begin
    prev_base = clear_position ? encoder_count : previous_count;
    pos_base  = clear_position ? '0 : position_acc;
    diff      = $signed({1'b0, encoder_count}) - $signed({1'b0, prev_base});
    // wrap through zero of the free-running counter
    priority if (diff > WRAP_THRESHOLD) begin
      ticks = $signed(diff - COUNT_SPAN);
    end else if (diff < -WRAP_THRESHOLD) begin
      ticks = $signed(diff + COUNT_SPAN);
    end else begin
      ticks = diff;
    end
    pos_new  = pos_base + DATA_W'(ticks);
    perr_new = target_position - pos_new;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_acc   <= '0;
      previous_count <= '0;
    end else if (stg_adv[0] && in_valid) begin
      position_acc   <= pos_new;
      previous_count <= encoder_count;
    end
  end

  logic signed [DATA_W-1:0] s1_pos;
  logic signed [DATA_W-1:0] s1_perr;
  logic signed [TICK_W-1:0] s1_ticks;
  logic signed [DATA_W-1:0] s1_tspeed;
  logic                     s1_homing;

  always_ff @(posedge clk) begin
    if (stg_adv[0]) begin
      s1_pos    <= pos_new;
      s1_perr   <= perr_new;
      s1_ticks  <= ticks;
      s1_tspeed <= target_speed;
      s1_homing <= homing_active;
    end
  end

  // ---------------- S2: speed error, position integral ----------------
  // PID state keeps running after a stall latch; outputs are masked from then on
  logic signed [DATA_W-1:0] pos_integral;
  logic signed [DATA_W-1:0] pos_prev_error;
  logic signed [29:0]       speed;
  logic signed [DATA_W-1:0] serr;
  logic signed [DATA_W-1:0] pos_integral_next;
  logic signed [DATA_W:0]   pos_derr;

  always_comb begin
    speed             = s1_ticks * $signed({1'b0, SCALE});
    serr              = sat32(33'(s1_tspeed) - 33'(speed));
    pos_integral_next = sat32(33'(pos_integral) + 33'(s1_perr));
    pos_derr          = 33'(s1_perr) - 33'(pos_prev_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_integral   <= '0;
      pos_prev_error <= '0;
    end else if (stg_adv[1] && stg_valid[0] && loop_mode[0]) begin
      pos_integral   <= pos_integral_next;
      pos_prev_error <= s1_perr;
    end
  end

  logic signed [DATA_W-1:0] s2_ep;
  logic signed [DATA_W-1:0] s2_ip;
  logic signed [DATA_W:0]   s2_dp;
  logic signed [DATA_W-1:0] s2_es;
  side_t                    s2_side;

  always_ff @(posedge clk) begin
    if (stg_adv[1]) begin
      s2_ep   <= s1_perr;
      s2_ip   <= pos_integral_next;
      s2_dp   <= pos_derr;
      s2_es   <= serr;
      s2_side <= '{position: s1_pos, perr: s1_perr,
                   speed_zero: (s1_ticks == '0), homing: s1_homing};
    end
  end

  // ---------------- S3: speed integral ----------------
  logic signed [DATA_W-1:0] speed_integral;
  logic signed [DATA_W-1:0] speed_prev_error;
  logic signed [DATA_W-1:0] speed_integral_next;
  logic signed [DATA_W:0]   speed_derr;

  always_comb begin
    speed_integral_next = sat32(33'(speed_integral) + 33'(s2_es));
    speed_derr          = 33'(s2_es) - 33'(speed_prev_error);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_integral   <= '0;
      speed_prev_error <= '0;
    end else if (stg_adv[2] && stg_valid[1] && loop_mode[1]) begin
      speed_integral   <= speed_integral_next;
      speed_prev_error <= s2_es;
    end
  end

  logic signed [DATA_W-1:0] s3_ep;
  logic signed [DATA_W-1:0] s3_ip;
  logic signed [DATA_W:0]   s3_dp;
  logic signed [DATA_W-1:0] s3_es;
  logic signed [DATA_W-1:0] s3_is;
  logic signed [DATA_W:0]   s3_ds;
  side_t                    s3_side;

  always_ff @(posedge clk) begin
    if (stg_adv[2]) begin
      s3_ep   <= s2_ep;
      s3_ip   <= s2_ip;
      s3_dp   <= s2_dp;
      s3_es   <= s2_es;
      s3_is   <= speed_integral_next;
      s3_ds   <= speed_derr;
      s3_side <= s2_side;
    end
  end

  // ---------------- S4..S8: PID lanes ----------------
  logic signed [PID_W-1:0] pid_pos;
  logic signed [PID_W-1:0] pid_speed;
  side_t                   side_pipe [5];

  epmc_pid_lane u_pos_lane (
    .clk          (clk),
    .adv          (stg_adv[7:3]),
    .err          (s3_ep),
    .integ        (s3_ip),
    .derr         (s3_dp),
    .gain_p_centi (pos_gain_p_centi),
    .gain_i_milli (pos_gain_i_milli),
    .gain_d       (pos_gain_d),
    .pid          (pid_pos)
  );

  epmc_pid_lane u_speed_lane (
    .clk          (clk),
    .adv          (stg_adv[7:3]),
    .err          (s3_es),
    .integ        (s3_is),
    .derr         (s3_ds),
    .gain_p_centi (speed_gain_p_centi),
    .gain_i_milli (speed_gain_i_milli),
    .gain_d       (speed_gain_d),
    .pid          (pid_speed)
  );

  always_ff @(posedge clk) begin
    if (stg_adv[3]) side_pipe[0] <= s3_side;
    for (int i = 1; i < 5; i++) begin
      if (stg_adv[3+i]) side_pipe[i] <= side_pipe[i-1];
    end
  end

  // ---------------- S9: control accumulate, clamp, stall ----------------
  logic signed [CTL_W-1:0]  control_acc;
  logic [CNT_W-1:0]         stall_count;
  logic                     active_flag;
  logic signed [PID_W-1:0]  ctl_add;
  logic signed [PID_W:0]    ctl_sum;
  logic signed [PID_W:0]    lim_wide;
  logic signed [CTL_W-1:0]  ctl_clamped;
  logic                     stall_cond;
  logic [CNT_W:0]           stall_inc;
  logic [CNT_W:0]           stall_lim;
  logic                     trip;
  logic                     active_next;
  logic [CNT_W-1:0]         stall_next;
  logic signed [CTL_W-1:0]  ctl_final;

  always_comb begin
    unique case (loop_mode_t'(loop_mode))
      MODE_POS:   ctl_add = pid_pos;
      MODE_SPEED: ctl_add = pid_speed;
      MODE_NONE:  ctl_add = '0;
      MODE_BOTH:  ctl_add = '0;
    endcase
    ctl_sum  = (PID_W+1)'(control_acc) + (PID_W+1)'(ctl_add);
    lim_wide = $signed((PID_W+1)'(control_limit));
    priority if (ctl_sum > lim_wide) begin
      ctl_clamped = CTL_W'(lim_wide);
    end else if (ctl_sum < -lim_wide) begin
      ctl_clamped = CTL_W'(-lim_wide);
    end else begin
      ctl_clamped = CTL_W'(ctl_sum);
    end
    stall_cond = active_flag && (ctl_clamped > STALL_THR || ctl_clamped < -STALL_THR) &&
                 side_pipe[4].speed_zero && (side_pipe[4].perr != '0);
    stall_inc   = {1'b0, stall_count} + 17'd1;
    stall_lim   = side_pipe[4].homing ? LIM_HOMING : LIM_NORMAL;
    trip        = stall_cond && (stall_inc > stall_lim);
    active_next = active_flag && !trip;
    stall_next  = (stall_cond && !trip) ? stall_inc[CNT_W-1:0] : '0;
    ctl_final   = active_next ? ctl_clamped : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      control_acc <= '0;
      stall_count <= '0;
      active_flag <= 1'b1;
    end else if (stg_adv[8] && stg_valid[7]) begin
      control_acc <= ctl_final;
      stall_count <= stall_next;
      active_flag <= active_next;
    end
  end

  logic signed [DATA_W-1:0] s9_pos;
  logic signed [DATA_W-1:0] s9_perr;
  logic signed [CTL_W-1:0]  s9_ctl;
  logic                     s9_active;
  logic                     s9_fault;

  always_ff @(posedge clk) begin
    if (stg_adv[8]) begin
      s9_pos    <= side_pipe[4].position;
      s9_perr   <= side_pipe[4].perr;
      s9_ctl    <= ctl_final;
      s9_active <= active_next;
      s9_fault  <= trip;
    end
  end

  // ---------------- S10: PWM compare levels, result register ----------------
  logic [LIMIT_W-1:0]  ctl_mag;
  logic [28:0]         duty_prod;
  logic [7:0]          duty;
  logic [LEVEL_W-1:0]  level_drive;

  always_comb begin
    ctl_mag     = LIMIT_W'((s9_ctl < 0) ? -s9_ctl : s9_ctl);
    duty_prod   = ctl_mag * DIV100_RECIP;
    duty        = duty_prod[28:DIV100_SHIFT];
    level_drive = (duty > 8'(LEVEL_IDLE)) ? '0 : LEVEL_W'(8'(LEVEL_IDLE) - duty);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ccw_compare <= LEVEL_IDLE;
      cw_compare  <= LEVEL_IDLE;
    end else if (stg_adv[9] && stg_valid[8]) begin
      position       <= s9_pos;
      position_error <= s9_perr;
      control_value  <= s9_ctl;
      motor_active   <= s9_active;
      stall_fault    <= s9_fault;
      // zero control leaves both levels where they were
      priority if (!s9_active) begin
        ccw_compare <= LEVEL_IDLE;
        cw_compare  <= LEVEL_IDLE;
      end else if (s9_ctl < 0) begin
        ccw_compare <= LEVEL_IDLE;
        cw_compare  <= level_drive;
      end else if (s9_ctl > 0) begin
        ccw_compare <= level_drive;
        cw_compare  <= LEVEL_IDLE;
      end else begin
        ccw_compare <= ccw_compare;
        cw_compare  <= cw_compare;
      end
    end
  end

  // ---------------- assertions ----------------
  a_active_latched: assert property (@(posedge clk) disable iff (rst)
    !$rose(active_flag))
    else $error("motor re-enabled without reset");

  a_fault_inactive: assert property (@(posedge clk) disable iff (rst)
    out_valid && stall_fault |-> !motor_active)
    else $error("stall fault reported with motor still active");

  a_idle_outputs: assert property (@(posedge clk) disable iff (rst)
    out_valid && !motor_active |->
      ccw_compare == LEVEL_IDLE && cw_compare == LEVEL_IDLE && control_value == '0)
    else $error("inactive motor still driven");

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ccw_compare == LEVEL_IDLE || cw_compare == LEVEL_IDLE)
    else $error("both PWM sides driven");

endmodule

[hw/rtl/epmc_pid_lane.sv]
// ----------------------------------------------------------------------------
// epmc_pid_lane
// Five-stage PID arithmetic: gain products, trunc-toward-zero divide by 1000
// (shift by 3, reciprocal multiply by 1/125 in partial products), D term add.
// ----------------------------------------------------------------------------
module epmc_pid_lane
  import epmc_pkg::*;
(
  input  logic                     clk,
  input  logic [4:0]               adv,
  input  logic signed [DATA_W-1:0] err,
  input  logic signed [DATA_W-1:0] integ,
  input  logic signed [DATA_W:0]   derr,
  input  logic [GAIN_W-1:0]        gain_p_centi,
  input  logic [GAIN_W-1:0]        gain_i_milli,
  input  logic [GAIN_W-1:0]        gain_d,
  output logic signed [PID_W-1:0]  pid
);

  localparam int Q_W = 42;

  // L0: gain products
  logic signed [48:0] l0_pe;
  logic signed [48:0] l0_pi;
  logic signed [49:0] l0_pd;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      l0_pe <= err * $signed({1'b0, gain_p_centi});
      l0_pi <= integ * $signed({1'b0, gain_i_milli});
      l0_pd <= derr * $signed({1'b0, gain_d});
    end
  end

  // L1: A = 10*P + I, split into magnitude / 8 and the dropped bits
  logic signed [51:0] a_sum;
  logic [51:0]        a_mag;
  logic [47:0]        l1_m;
  logic               l1_low_nz;
  logic               l1_neg;
  logic signed [49:0] l1_pd;

  assign a_sum = (52'(l0_pe) <<< 3) + (52'(l0_pe) <<< 1) + 52'(l0_pi);
  assign a_mag = a_sum[51] ? 52'(-a_sum) : 52'(a_sum);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      l1_m      <= a_mag[50:3];
      l1_low_nz <= |a_mag[2:0];
      l1_neg    <= a_sum[51];
      l1_pd     <= l0_pd;
    end
  end

  // L2: partial products of m * (2^55 / 125)
  logic [48:0]        l2_hh;
  logic [47:0]        l2_hl;
  logic [48:0]        l2_lh;
  logic [47:0]        l2_ll;
  logic [47:0]        l2_m;
  logic               l2_low_nz;
  logic               l2_neg;
  logic signed [49:0] l2_pd;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      l2_hh     <= l1_m[47:24] * DIV125_RECIP[48:24];
      l2_hl     <= l1_m[47:24] * DIV125_RECIP[23:0];
      l2_lh     <= l1_m[23:0] * DIV125_RECIP[48:24];
      l2_ll     <= l1_m[23:0] * DIV125_RECIP[23:0];
      l2_m      <= l1_m;
      l2_low_nz <= l2_low_nz_in(l1_low_nz);
      l2_neg    <= l1_neg;
      l2_pd     <= l1_pd;
    end
  end

  function automatic logic l2_low_nz_in(input logic v);
    return v;
  endfunction

  // L3: sum partials, quotient of |A| / 1000
  logic [96:0]        prod;
  logic [Q_W-1:0]     l3_q;
  logic [47:0]        l3_m;
  logic               l3_low_nz;
  logic               l3_neg;
  logic signed [49:0] l3_pd;

  assign prod = {l2_hh, 48'd0} + (97'(l2_hl) << 24) + (97'(l2_lh) << 24) + 97'(l2_ll);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      l3_q      <= prod[96:DIV125_SHIFT];
      l3_m      <= l2_m;
      l3_low_nz <= l2_low_nz;
      l3_neg    <= l2_neg;
      l3_pd     <= l2_pd;
    end
  end

  // L4: restore sign, add D term, fix truncation when the remainder is nonzero
  logic [49:0]              q125;
  logic                     rem_nz;
  logic signed [PID_W-1:0]  q_ext;
  logic signed [PID_W-1:0]  pid_raw;
  logic signed [PID_W-1:0]  pid_adj;

  always_comb begin
    q125    = (50'(l3_q) << 7) - (50'(l3_q) << 2) + 50'(l3_q);
    rem_nz  = l3_low_nz || (q125 != 50'(l3_m));
    q_ext   = $signed(PID_W'(l3_q));
    pid_raw = (l3_neg ? -q_ext : q_ext) + PID_W'(l3_pd);
    priority if (rem_nz && !l3_neg && pid_raw < 0) begin
      pid_adj = pid_raw + 51'sd1;
    end else if (rem_nz && l3_neg && pid_raw > 0) begin
      pid_adj = pid_raw - 51'sd1;
    end else begin
      pid_adj = pid_raw;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      pid <= pid_adj;
    end
  end

endmodule
